FILE: rtl/tstmc_pkg.sv
`default_nettype none

package tstmc_pkg;

  // Core sizes
  localparam int LEVEL_MAX   = 1000;
  localparam int SAMPLE_BITS = 10;

  localparam int PRESS_W   = 10;
  localparam int POS_W     = 10;
  localparam int GAIN_W    = 5;
  localparam int PULSE_W   = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam int LEVEL_W  = $clog2(LEVEL_MAX + 1);
  localparam int MOVE_W   = PRESS_W + GAIN_W;
  localparam int MOVE10_W = MOVE_W + 4;
  localparam int PROD_W   = LEVEL_W + PULSE_W;

  // Hold mode set points
  localparam int HOLD_UP_BASE   = 600;
  localparam int HOLD_DOWN_BASE = 400;
  localparam int HOLD_STEP      = 10;

  // Divide by LEVEL_MAX as a multiply by the rounded-up reciprocal. Exact for the
  // whole product range: product * error stays below 2^RECIP_SHIFT.
  localparam int     RECIP_SHIFT = 32;
  localparam longint RECIP       = ((64'd1 << RECIP_SHIFT) + LEVEL_MAX - 1) / LEVEL_MAX;
  localparam int     RECIP_W     = $clog2(RECIP + 1);

  localparam logic [PRESS_W-1:0] SAMPLE_MASK = PRESS_W'((64'd1 << SAMPLE_BITS) - 1);

  // Controller to datapath commands
  typedef struct packed {
    logic take;    // latch sample, classify, update mode and latch
    logic level;   // update throttle level
    logic mult;    // level times pulse span
    logic finish;  // scale and load the result register
  } tstmc_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/tstmc_ctrl.sv
`default_nettype none

module tstmc_ctrl
  import tstmc_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  wire        m_tready,
  output tstmc_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEVEL,
    S_MULT,
    S_DIV
  } state_t;

  state_t state;

  assign s_tready   = (state == S_IDLE);
  assign cmd.take   = s_tready && s_tvalid;
  assign cmd.level  = (state == S_LEVEL);
  assign cmd.mult   = (state == S_MULT);
  // hold in S_DIV while the previous result is still waiting
  assign cmd.finish = (state == S_DIV) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.take) state <= S_LEVEL;
        end
        S_LEVEL: state <= S_MULT;
        S_MULT:  state <= S_DIV;
        S_DIV: begin
          if (cmd.finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tstmc_dp.sv
`default_nettype none

module tstmc_dp
  import tstmc_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  tstmc_cmd_t          cmd,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [CFG_W-1:0]     cfg_data,
  input  wire [PRESS_W-1:0]   sample_pressure,
  input  wire [POS_W-1:0]     sample_position,
  output logic                out_pulse_valid,
  output logic [PULSE_W-1:0]  out_pulse,
  output logic                out_toggled,
  output logic                out_alt_hold
);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOUCH_THR,
    REG_MODE_THR,
    REG_UPPER_ZONE,
    REG_LOWER_ZONE,
    REG_GAIN,
    REG_CENTER_PULSE,
    REG_PULSE_LOW,
    REG_PULSE_HIGH
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DEC_RELEASE,
    DEC_TOGGLE,
    DEC_UP,
    DEC_DOWN,
    DEC_KEEP
  } decision_t;

  localparam int SUM_W = MOVE10_W + 1;
  localparam int QF_W  = PROD_W + RECIP_W;

  // Configuration registers
  logic [PRESS_W-1:0] touch_threshold;
  logic [PRESS_W-1:0] mode_press_threshold;
  logic [POS_W-1:0]   upper_zone_start;
  logic [POS_W-1:0]   lower_zone_end;
  logic [GAIN_W-1:0]  pressure_gain;
  logic [PULSE_W-1:0] center_pulse;
  logic [PULSE_W-1:0] pulse_low;
  logic [PULSE_W-1:0] pulse_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_threshold      <= PRESS_W'(100);
      mode_press_threshold <= PRESS_W'(900);
      upper_zone_start     <= POS_W'(600);
      lower_zone_end       <= POS_W'(400);
      pressure_gain        <= GAIN_W'(1);
      center_pulse         <= PULSE_W'(1500);
      pulse_low            <= PULSE_W'(1000);
      pulse_high           <= PULSE_W'(2000);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOUCH_THR:    touch_threshold      <= cfg_data[PRESS_W-1:0];
        REG_MODE_THR:     mode_press_threshold <= cfg_data[PRESS_W-1:0];
        REG_UPPER_ZONE:   upper_zone_start     <= cfg_data[POS_W-1:0];
        REG_LOWER_ZONE:   lower_zone_end       <= cfg_data[POS_W-1:0];
        REG_GAIN:         pressure_gain        <= cfg_data[GAIN_W-1:0];
        REG_CENTER_PULSE: center_pulse         <= cfg_data[PULSE_W-1:0];
        REG_PULSE_LOW:    pulse_low            <= cfg_data[PULSE_W-1:0];
        REG_PULSE_HIGH:   pulse_high           <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the incoming sample
  logic [PRESS_W-1:0] pressure;
  logic [POS_W-1:0]   position;
  decision_t          decision_next;
  logic [MOVE_W-1:0]  move_next;

  assign pressure  = sample_pressure & SAMPLE_MASK;
  assign position  = sample_position & SAMPLE_MASK;
  assign move_next = MOVE_W'(pressure) * MOVE_W'(pressure_gain);

  logic hold_mode;
  logic toggle_latch;

  always_comb begin
    if (pressure < touch_threshold) begin
      decision_next = DEC_RELEASE;
    end else if (!toggle_latch && pressure > mode_press_threshold &&
                 position < upper_zone_start && position > lower_zone_end) begin
      decision_next = DEC_TOGGLE;
    end else if (position > upper_zone_start) begin
      decision_next = DEC_UP;
    end else if (position < lower_zone_end) begin
      decision_next = DEC_DOWN;
    end else begin
      decision_next = DEC_KEEP;
    end
  end

  decision_t         decision;
  logic [MOVE_W-1:0] move;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_mode    <= 1'b0;
      toggle_latch <= 1'b0;
    end else if (cmd.take) begin
      case (decision_next)
        DEC_RELEASE: toggle_latch <= 1'b0;
        DEC_TOGGLE: begin
          toggle_latch <= 1'b1;
          hold_mode    <= ~hold_mode;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      decision <= decision_next;
      move     <= move_next;
    end
  end

  // Throttle level update
  logic [LEVEL_W-1:0]  throttle_level;
  logic [MOVE10_W-1:0] move10;
  logic [SUM_W-1:0]    level_cand;
  logic [SUM_W-1:0]    level_clamped;

  assign move10 = MOVE10_W'(move) * MOVE10_W'(HOLD_STEP);

  always_comb begin
    level_cand = SUM_W'(throttle_level);
    case (decision)
      DEC_UP: begin
        if (hold_mode) level_cand = SUM_W'(HOLD_UP_BASE) + SUM_W'(move10);
        else           level_cand = SUM_W'(throttle_level) + SUM_W'(move);
      end
      DEC_DOWN: begin
        if (hold_mode) begin
          if (SUM_W'(move10) >= SUM_W'(HOLD_DOWN_BASE)) level_cand = '0;
          else level_cand = SUM_W'(HOLD_DOWN_BASE) - SUM_W'(move10);
        end else begin
          if (SUM_W'(move) > SUM_W'(throttle_level)) level_cand = '0;
          else level_cand = SUM_W'(throttle_level) - SUM_W'(move);
        end
      end
      default: level_cand = SUM_W'(throttle_level);
    endcase
    if (level_cand > SUM_W'(LEVEL_MAX)) level_clamped = SUM_W'(LEVEL_MAX);
    else                               level_clamped = level_cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_level <= '0;
    end else if (cmd.level) begin
      throttle_level <= level_clamped[LEVEL_W-1:0];
    end
  end

  // Level times span, then divide by LEVEL_MAX
  logic               span_neg_next;
  logic [PULSE_W-1:0] span_mag;
  logic               span_neg;
  logic [PROD_W-1:0]  prod;

  assign span_neg_next = (pulse_high < pulse_low);
  assign span_mag      = span_neg_next ? (pulse_low - pulse_high) : (pulse_high - pulse_low);

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod     <= PROD_W'(throttle_level) * PROD_W'(span_mag);
      span_neg <= span_neg_next;
    end
  end

  logic [QF_W-1:0]    quot_full;
  logic [PULSE_W-1:0] quot;
  logic [PULSE_W-1:0] pulse_calc;

  assign quot_full  = QF_W'(prod) * QF_W'(RECIP);
  assign quot       = quot_full[RECIP_SHIFT +: PULSE_W];
  assign pulse_calc = span_neg ? (pulse_low - quot) : (pulse_low + quot);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_alt_hold <= hold_mode;
      case (decision)
        DEC_RELEASE: begin
          out_pulse_valid <= hold_mode;
          out_pulse       <= hold_mode ? center_pulse : '0;
          out_toggled     <= 1'b0;
        end
        DEC_TOGGLE: begin
          out_pulse_valid <= 1'b0;
          out_pulse       <= '0;
          out_toggled     <= 1'b1;
        end
        default: begin
          out_pulse_valid <= 1'b1;
          out_pulse       <= pulse_calc;
          out_toggled     <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/touch_strip_throttle_mode_control_unit.sv
`default_nettype none

// Channel   Direction  Payload
// s_*       in         tdata: pressure[9:0], position[19:10], zero pad
// m_*       out        tdata: throttle_pulse[11:0], mode_toggled[12], alt_hold[13];
//                      tuser: pulse_valid
// cfg_*     in         write enable, register index 0..7, data up to 12 bits
//
// Per sample: the request is classified and move formed on the accept edge, then
// level update, level*span multiply and reciprocal divide follow in S_LEVEL, S_MULT
// and S_DIV; s_tready stays low until the result is loaded.
// A result waiting in the output register does not block the next request;
// only a second finished result stalls in the divide step until m_tready.
// Synchronous reset returns level, mode, latch and configuration registers to their defaults.

module touch_strip_throttle_mode_control_unit
  import tstmc_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  wire [IN_TDATA_W-1:0]  s_tdata,   // pressure[9:0], position[19:10]
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // throttle_pulse[11:0], mode_toggled[12], alt_hold[13]
  output logic                  m_tuser,   // pulse_valid
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_W-1:0]       cfg_data
);

  tstmc_cmd_t         cmd;
  logic               pulse_valid;
  logic [PULSE_W-1:0] throttle_pulse;
  logic               mode_toggled;
  logic               alt_hold;

  tstmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tstmc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_pressure (s_tdata[PRESS_W-1:0]),
    .sample_position (s_tdata[PRESS_W +: POS_W]),
    .out_pulse_valid (pulse_valid),
    .out_pulse       (throttle_pulse),
    .out_toggled     (mode_toggled),
    .out_alt_hold    (alt_hold)
  );

  assign m_tdata = {(OUT_TDATA_W - PULSE_W - 2)'(0), alt_hold, mode_toggled, throttle_pulse};
  assign m_tuser = pulse_valid;

endmodule

`default_nettype wire

FILE: rtl/tstmc_chk.sv
`default_nettype none

module tstmc_chk
  import tstmc_pkg::*;
(
  input wire                   clk,
  input wire                   rst,
  input wire                   s_tvalid,
  input wire                   s_tready,
  input wire                   m_tvalid,
  input wire                   m_tready,
  input wire [OUT_TDATA_W-1:0] m_tdata,
  input wire                   m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // an accepted request keeps the input closed through the level, multiply and divide states
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("request accepted while busy");

  // no pulse means a zero pulse field
  a_no_pulse_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[PULSE_W-1:0] == '0)
    else $error("pulse field set without pulse_valid");

  // a mode toggle never carries a pulse
  a_toggle_no_pulse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[PULSE_W] |-> !m_tuser)
    else $error("pulse emitted on mode toggle");

endmodule

bind touch_strip_throttle_mode_control_unit tstmc_chk u_tstmc_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
